@@ rtl/core/lzw_byte_encoder_core_defines.svh @@
// Assertion macros shared by the encoder checker
`ifndef LZW_BYTE_ENCODER_CORE_DEFINES_SVH
`define LZW_BYTE_ENCODER_CORE_DEFINES_SVH

// Check a next-cycle implication outside reset
`define LZWE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzw encoder check failed");

// Check a next-cycle implication, reset cycles included
`define LZWE_ASSERT_NEXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lzw encoder check failed");

`endif

@@ rtl/core/lzwe_pkg.sv @@
// Shared constants, types and hash function of the LZW byte encoder
`default_nettype none
package lzwe_pkg;

  localparam int CODE_BITS = 12;
  localparam int BYTE_BITS = 8;
  localparam int SLOT_BITS = 13;
  localparam int HASH_SLOTS = 1 << SLOT_BITS;
  localparam int NFC_BITS = CODE_BITS + 1;

  localparam logic [NFC_BITS-1:0] FIRST_CODE = NFC_BITS'(257);
  localparam logic [CODE_BITS-1:0] MAX_CODE_RESET = CODE_BITS'(4095);

  // One dictionary slot
  typedef struct packed {
    logic                 valid;
    logic [CODE_BITS-1:0] prefix;
    logic [BYTE_BITS-1:0] data;
    logic [CODE_BITS-1:0] code;
  } slot_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic insert;
    logic probe;
    logic take_hit;
    logic emit_miss;
    logic emit_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic prefix_valid;
    logic eos;
    logic empty;
    logic hit;
    logic slot_free;
    logic clear_done;
  } dp_status_t;

  // Mix prefix and byte into a slot index
  function automatic logic [SLOT_BITS-1:0] hash_slot(logic [CODE_BITS-1:0] pre,
                                                     logic [BYTE_BITS-1:0] b);
    logic [31:0] key;
    logic [31:0] mixed;
    key = (32'(pre) << 8) | 32'(b);
    mixed = key ^ (key >> 7) ^ (key << 3);
    return mixed[SLOT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/lzwe_ctrl.sv @@
// Sequencing state machine of the LZW byte encoder
`default_nettype none
module lzwe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                end_of_stream,
  output logic                     in_ready,
  input  wire lzwe_pkg::dp_status_t st,
  output lzwe_pkg::dp_cmd_t        cmd
);
  import lzwe_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LOOK  = 6'b000100,
    S_CHECK = 6'b001000,
    S_MISS  = 6'b010000,
    S_LAST  = 6'b100000
  } state_t;

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and datapath commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.prefix_valid) state_next = S_LOOK;
          else if (end_of_stream) state_next = S_LAST;
        end
      end
      S_LOOK: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.empty) begin
          cmd.insert = 1'b1;
          state_next = S_MISS;
        end else if (st.hit) begin
          cmd.take_hit = 1'b1;
          state_next = st.eos ? S_LAST : S_IDLE;
        end else begin
          cmd.probe = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_MISS: begin
        if (st.slot_free) begin
          cmd.emit_miss = 1'b1;
          state_next = st.eos ? S_LAST : S_IDLE;
        end
      end
      S_LAST: begin
        if (st.slot_free) begin
          cmd.emit_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/lzwe_dpath.sv @@
// Dictionary memory, prefix registers and output register of the encoder
`default_nettype none
module lzwe_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [lzwe_pkg::BYTE_BITS-1:0]    data_byte,
  input  wire logic                              end_of_stream,
  input  wire logic                              cfg_write_en,
  input  wire logic [lzwe_pkg::CODE_BITS-1:0]    cfg_write_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [lzwe_pkg::CODE_BITS-1:0]         code,
  output logic                                   last_code,
  input  wire lzwe_pkg::dp_cmd_t                 cmd,
  output lzwe_pkg::dp_status_t                   st
);
  import lzwe_pkg::*;

  slot_t                mem [HASH_SLOTS];
  slot_t                rd_slot;
  logic [SLOT_BITS-1:0] addr;
  logic [CODE_BITS-1:0] prefix;
  logic                 prefix_valid;
  logic [BYTE_BITS-1:0] byte_r;
  logic                 eos_r;
  logic [NFC_BITS-1:0]  next_free;
  logic [CODE_BITS-1:0] max_code;
  logic                 can_add;
  slot_t                new_slot;

  assign can_add = next_free <= {1'b0, max_code};

  always_comb begin
    new_slot.valid  = 1'b1;
    new_slot.prefix = prefix;
    new_slot.data   = byte_r;
    new_slot.code   = next_free[CODE_BITS-1:0];
  end

  // Write and read the dictionary
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[addr] <= '0;
    end else if (cmd.insert && can_add) begin
      mem[addr] <= new_slot;
    end
    rd_slot <= mem[addr];
  end

  // Advance the slot address
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (cmd.accept) begin
      addr <= hash_slot(prefix, data_byte);
    end else if (cmd.clear_step || cmd.probe) begin
      addr <= addr + 1'b1;
    end
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= data_byte;
      eos_r  <= end_of_stream;
    end
  end

  // Track prefix and code allocation
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix       <= '0;
      prefix_valid <= 1'b0;
      next_free    <= FIRST_CODE;
      max_code     <= MAX_CODE_RESET;
    end else begin
      if (cfg_write_en) max_code <= cfg_write_data;
      if (cmd.accept && !prefix_valid) begin
        prefix       <= CODE_BITS'(data_byte);
        prefix_valid <= 1'b1;
      end else if (cmd.take_hit) begin
        prefix <= rd_slot.code;
      end else if (cmd.emit_miss) begin
        prefix <= CODE_BITS'(byte_r);
      end else if (cmd.emit_last) begin
        prefix       <= '0;
        prefix_valid <= 1'b0;
      end
      if (cmd.insert && can_add) next_free <= next_free + 1'b1;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_miss || cmd.emit_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_miss || cmd.emit_last) begin
      code      <= prefix;
      last_code <= cmd.emit_last;
    end
  end

  always_comb begin
    st.prefix_valid = prefix_valid;
    st.eos          = eos_r;
    st.empty        = !rd_slot.valid;
    st.hit          = rd_slot.valid && rd_slot.prefix == prefix && rd_slot.data == byte_r;
    st.slot_free    = !out_valid || out_ready;
    st.clear_done   = &addr;
  end

endmodule
`default_nettype wire

@@ rtl/core/lzw_byte_encoder_core.sv @@
// LZW byte encoder top level: controller plus datapath
// After reset the block sweeps and clears its 8192-slot dictionary with
// in_ready low; configuration writes are taken throughout. A byte that starts
// a new prefix just becomes the prefix. Any other byte goes through accept,
// dictionary read and compare, then a further read and compare for each
// slot probed on a hash collision, and each code it emits waits until the
// output register is free. The dictionary memory is single-ported with a
// registered read. Codes come out of a one-item output register with
// valid/ready; last_code marks the flushed end-of-stream code.
`default_nettype none
module lzw_byte_encoder_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lzwe_pkg::BYTE_BITS-1:0] data_byte,
  input  wire logic                           end_of_stream,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [lzwe_pkg::CODE_BITS-1:0]      code,
  output logic                                last_code,
  input  wire logic                           cfg_write_en,
  input  wire logic [lzwe_pkg::CODE_BITS-1:0] cfg_write_data
);
  import lzwe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  lzwe_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .end_of_stream (end_of_stream),
    .in_ready      (in_ready),
    .st            (st),
    .cmd           (cmd)
  );

  lzwe_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .end_of_stream  (end_of_stream),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .code           (code),
    .last_code      (last_code),
    .cmd            (cmd),
    .st             (st)
  );

endmodule
`default_nettype wire

@@ rtl/core/lzwe_checker.sv @@
// Port-level checks of the LZW byte encoder and their binding
`default_nettype none
`include "lzw_byte_encoder_core_defines.svh"
module lzwe_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           end_of_stream,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [lzwe_pkg::CODE_BITS-1:0] code,
  input wire logic                           last_code
);
  import lzwe_pkg::*;

  // Output register comes up empty
  `LZWE_ASSERT_NEXT_ANY(a_reset_empty, rst, !out_valid)
  // End of stream always leaves work behind, so the block is busy next
  `LZWE_ASSERT_NEXT(a_eos_busy, in_valid && in_ready && end_of_stream, !in_ready)
  // Stalled result holds
  `LZWE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(code) && $stable(last_code))
  // A fresh result never lands while the input is being taken
  `LZWE_ASSERT_NEXT(a_no_emit_on_accept, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind lzw_byte_encoder_core lzwe_checker u_lzwe_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .end_of_stream (end_of_stream),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .code          (code),
  .last_code     (last_code)
);
`default_nettype wire
